[hdl/volume_brightness_key_controller_core_defines.svh]
// Assertion helpers for the key controller core.
`ifndef VOLUME_BRIGHTNESS_KEY_CONTROLLER_CORE_DEFINES_SVH
`define VOLUME_BRIGHTNESS_KEY_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define VBK_ASSERT_HOLDS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vbk: invariant violated");
`define VBK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vbk: next-cycle check failed");
`else
`define VBK_ASSERT_HOLDS(label, cond)
`define VBK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/vbk_pkg.sv]
package vbk_pkg;

    localparam int unsigned LVL_W     = 6;
    localparam int unsigned CODE_W    = 10;
    localparam int unsigned VALUE_W   = 8;
    localparam int unsigned CFG_IDX_W = 3;

    // key codes
    localparam logic [CODE_W-1:0] CODE_MENU    = 10'd1;
    localparam logic [CODE_W-1:0] CODE_POWER   = 10'd116;
    localparam logic [CODE_W-1:0] CODE_VOLUP   = 10'd115;
    localparam logic [CODE_W-1:0] CODE_VOLDOWN = 10'd114;
    localparam logic [CODE_W-1:0] CODE_L1      = 10'd18;
    localparam logic [CODE_W-1:0] CODE_R1      = 10'd20;

    // key values
    localparam logic [VALUE_W-1:0] VAL_RELEASE = 8'd0;
    localparam logic [VALUE_W-1:0] VAL_PRESS   = 8'd1;
    localparam logic [VALUE_W-1:0] VAL_REPEAT  = 8'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PLUS_MODEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_VOLUME     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_BRIGHTNESS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_MUTE       = 3'd5;

    // reset values
    localparam logic             RST_PLUS_MODEL       = 1'b1;
    localparam logic [LVL_W-1:0] RST_VOLUME_MAX       = 6'd20;
    localparam logic [LVL_W-1:0] RST_BRIGHTNESS_MAX   = 6'd10;
    localparam logic [LVL_W-1:0] RST_START_VOLUME     = 6'd10;
    localparam logic [LVL_W-1:0] RST_START_BRIGHTNESS = 6'd5;
    localparam logic             RST_START_MUTE       = 1'b0;

    typedef struct packed {
        logic             plus_model;
        logic [LVL_W-1:0] volume_max;
        logic [LVL_W-1:0] brightness_max;
    } cfg_t;

    typedef struct packed {
        logic             volume;
        logic             brightness;
        logic             mute;
        logic [LVL_W-1:0] data;
    } cfg_load_t;

    typedef struct packed {
        logic             menu_held;
        logic             power_held;
        logic             repeat_phase;
        logic [LVL_W-1:0] volume_now;
        logic [LVL_W-1:0] brightness_now;
        logic             muted;
    } state_t;

    typedef struct packed {
        logic                      is_key_event;
        logic [CODE_W-1:0]         key_code;
        logic signed [VALUE_W-1:0] key_value;
    } event_t;

    typedef struct packed {
        logic [LVL_W-1:0] volume_level;
        logic [LVL_W-1:0] brightness_level;
        logic             mute_on;
        logic             shutdown_request;
    } result_t;

endpackage

[hdl/vbk_cfg.sv]
module vbk_cfg
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [vbk_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [vbk_pkg::LVL_W-1:0]      wr_data,
    output vbk_pkg::cfg_t                  cfg,
    output vbk_pkg::cfg_load_t             load
);

    vbk_pkg::cfg_t cfg_reg;
    vbk_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next        = cfg_reg;
        load.volume     = 1'b0;
        load.brightness = 1'b0;
        load.mute       = 1'b0;
        load.data       = wr_data;
        if (wr_en)
        begin
            unique case (wr_index)
                vbk_pkg::REG_PLUS_MODEL:       cfg_next.plus_model     = wr_data[0];
                vbk_pkg::REG_VOLUME_MAX:       cfg_next.volume_max     = wr_data;
                vbk_pkg::REG_BRIGHTNESS_MAX:   cfg_next.brightness_max = wr_data;
                vbk_pkg::REG_START_VOLUME:     load.volume             = 1'b1;
                vbk_pkg::REG_START_BRIGHTNESS: load.brightness         = 1'b1;
                vbk_pkg::REG_START_MUTE:       load.mute               = 1'b1;
                default:                       cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plus_model     <= vbk_pkg::RST_PLUS_MODEL;
            cfg_reg.volume_max     <= vbk_pkg::RST_VOLUME_MAX;
            cfg_reg.brightness_max <= vbk_pkg::RST_BRIGHTNESS_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/vbk_step.sv]
module vbk_step
(
    input  vbk_pkg::state_t  st,
    input  vbk_pkg::cfg_t    cfg,
    input  vbk_pkg::event_t  ev,
    output vbk_pkg::state_t  st_next,
    output logic             shutdown
);

    always_comb
    begin
        logic [vbk_pkg::VALUE_W-1:0] v;
        logic                        known;
        logic                        is_up;
        logic                        is_down;
        logic                        act;
        logic [vbk_pkg::LVL_W-1:0]   vol;

        v       = $unsigned(ev.key_value);
        st_next = st;
        shutdown = 1'b0;
        known   = ev.is_key_event &&
                  (v == vbk_pkg::VAL_RELEASE || v == vbk_pkg::VAL_PRESS ||
                   v == vbk_pkg::VAL_REPEAT);
        is_up   = (ev.key_code == vbk_pkg::CODE_VOLUP) ||
                  (ev.key_code == vbk_pkg::CODE_R1 && !cfg.plus_model);
        is_down = (ev.key_code == vbk_pkg::CODE_VOLDOWN) ||
                  (ev.key_code == vbk_pkg::CODE_L1 && !cfg.plus_model);

        // repeats act on every second beat only
        if (v == vbk_pkg::VAL_REPEAT)
        begin
            act = st.repeat_phase;
        end
        else
        begin
            act = (v == vbk_pkg::VAL_PRESS);
        end

        vol = st.volume_now;

        if (known)
        begin
            if (ev.key_code == vbk_pkg::CODE_MENU)
            begin
                if (v != vbk_pkg::VAL_REPEAT)
                    st_next.menu_held = v[0];
            end
            else if (ev.key_code == vbk_pkg::CODE_POWER)
            begin
                if (v != vbk_pkg::VAL_REPEAT)
                    st_next.power_held = v[0];
            end
            else if (is_up || is_down)
            begin
                st_next.repeat_phase = (v == vbk_pkg::VAL_REPEAT) ? !st.repeat_phase : 1'b0;
                if (act && is_up)
                begin
                    if (st.menu_held)
                    begin
                        if (st.brightness_now < cfg.brightness_max)
                            st_next.brightness_now = st.brightness_now + 1'b1;
                    end
                    else
                    begin
                        if (st.volume_now < cfg.volume_max)
                            vol = st.volume_now + 1'b1;
                        st_next.volume_now = vol;
                        if (vol != '0)
                            st_next.muted = 1'b0;
                    end
                end
                else if (act)
                begin
                    if (st.menu_held)
                    begin
                        if (st.brightness_now != '0)
                            st_next.brightness_now = st.brightness_now - 1'b1;
                    end
                    else
                    begin
                        if (st.volume_now != '0)
                            vol = st.volume_now - 1'b1;
                        st_next.volume_now = vol;
                        if (vol == '0)
                            st_next.muted = 1'b1;
                    end
                end
            end

            if (st_next.menu_held && st_next.power_held)
            begin
                st_next.menu_held  = 1'b0;
                st_next.power_held = 1'b0;
                shutdown           = 1'b1;
            end
        end
    end

endmodule

[hdl/volume_brightness_key_controller_core.sv]
// Volume / brightness key controller.
// Input channel: in_valid / in_stall with is_key_event, key_code, key_value.
// One beat is taken at each edge where in_valid is high and in_stall low.
// Output channel: out_valid / out_stall; every input beat yields exactly one
// result beat with the levels, the mute flag and a one-beat shutdown pulse.
// A taken beat waits in the input register; its result is then registered
// for the output ports. Throughput is one beat per cycle while out_stall
// is low, set by the single update pass between input and result registers.
// While out_stall is high the result holds; the input register still takes
// one more beat, then in_stall rises until the result is taken.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects the
// register, cfg_data carries its value. Writing a start register also loads
// the live level or mute flag. Write only while no beat is in flight.
// Reset: registers take their defaults, levels load from the start values,
// held flags and the repeat phase clear, both channels go empty.
`include "volume_brightness_key_controller_core_defines.svh"

module volume_brightness_key_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 is_key_event,
    input  logic [vbk_pkg::CODE_W-1:0]           key_code,
    input  logic signed [vbk_pkg::VALUE_W-1:0]   key_value,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [vbk_pkg::LVL_W-1:0]            volume_level,
    output logic [vbk_pkg::LVL_W-1:0]            brightness_level,
    output logic                                 mute_on,
    output logic                                 shutdown_request,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [vbk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vbk_pkg::LVL_W-1:0]            cfg_data
);

    vbk_pkg::cfg_t      cfg;
    vbk_pkg::cfg_load_t load;
    vbk_pkg::state_t    st_reg;
    vbk_pkg::state_t    st_next;
    vbk_pkg::state_t    st_step;
    vbk_pkg::event_t    ev_reg;
    vbk_pkg::result_t   res_reg;
    logic               shut_step;
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_free;
    logic               s1_adv;
    logic               in_take;

    assign cfg_ready = 1'b1;

    vbk_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg),
        .load     (load)
    );

    vbk_step u_step
    (
        .st       (st_reg),
        .cfg      (cfg),
        .ev       (ev_reg),
        .st_next  (st_step),
        .shutdown (shut_step)
    );

    // handshake
    assign out_free       = !out_valid_reg || !out_stall;
    assign s1_adv         = s1_valid_reg && out_free;
    assign in_stall       = s1_valid_reg && !out_free;
    assign in_take        = in_valid && !in_stall;
    assign s1_valid_next  = in_take || (s1_valid_reg && !s1_adv);
    assign out_valid_next = s1_adv || (out_valid_reg && out_stall);

    always_comb
    begin
        st_next = s1_adv ? st_step : st_reg;
        if (load.volume)
            st_next.volume_now = load.data;
        if (load.brightness)
            st_next.brightness_now = load.data;
        if (load.mute)
            st_next.muted = load.data[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
            st_reg.menu_held      <= 1'b0;
            st_reg.power_held     <= 1'b0;
            st_reg.repeat_phase   <= 1'b0;
            st_reg.volume_now     <= vbk_pkg::RST_START_VOLUME;
            st_reg.brightness_now <= vbk_pkg::RST_START_BRIGHTNESS;
            st_reg.muted          <= vbk_pkg::RST_START_MUTE;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            st_reg        <= st_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_reg.is_key_event <= is_key_event;
            ev_reg.key_code     <= key_code;
            ev_reg.key_value    <= key_value;
        end
        if (s1_adv)
        begin
            res_reg.volume_level     <= st_step.volume_now;
            res_reg.brightness_level <= st_step.brightness_now;
            res_reg.mute_on          <= st_step.muted;
            res_reg.shutdown_request <= shut_step;
        end
    end

    assign out_valid        = out_valid_reg;
    assign volume_level     = res_reg.volume_level;
    assign brightness_level = res_reg.brightness_level;
    assign mute_on          = res_reg.mute_on;
    assign shutdown_request = res_reg.shutdown_request;

    `VBK_ASSERT_HOLDS(a_shut_clears_held,
        !(out_valid_reg && res_reg.shutdown_request) ||
        (!st_reg.menu_held && !st_reg.power_held))
    `VBK_ASSERT_NEXT(a_adv_fills_out, s1_adv, out_valid_reg)
    `VBK_ASSERT_NEXT(a_vol_bounded,
        s1_adv && !load.volume && st_reg.volume_now <= cfg.volume_max,
        st_reg.volume_now <= cfg.volume_max)

endmodule

[dv/volume_brightness_key_controller_core_tb.sv]
`timescale 1ns / 100ps

class level_tracker;
    logic                      plus_model;
    logic [vbk_pkg::LVL_W-1:0] volume_max;
    logic [vbk_pkg::LVL_W-1:0] brightness_max;
    logic [vbk_pkg::LVL_W-1:0] start_volume;
    logic [vbk_pkg::LVL_W-1:0] start_brightness;
    logic                      start_mute;

    logic                      menu_held;
    logic                      power_held;
    logic                      repeat_phase;
    logic [vbk_pkg::LVL_W-1:0] volume_now;
    logic [vbk_pkg::LVL_W-1:0] brightness_now;
    logic                      muted;

    vbk_pkg::result_t          expected_levels[$];
    int unsigned               errors;

    function new();
        plus_model       = vbk_pkg::RST_PLUS_MODEL;
        volume_max       = vbk_pkg::RST_VOLUME_MAX;
        brightness_max   = vbk_pkg::RST_BRIGHTNESS_MAX;
        start_volume     = vbk_pkg::RST_START_VOLUME;
        start_brightness = vbk_pkg::RST_START_BRIGHTNESS;
        start_mute       = vbk_pkg::RST_START_MUTE;
        menu_held        = 1'b0;
        power_held       = 1'b0;
        repeat_phase     = 1'b0;
        volume_now       = start_volume;
        brightness_now   = start_brightness;
        muted            = start_mute;
        errors           = 0;
    endfunction

    function void write_reg(logic [vbk_pkg::CFG_IDX_W-1:0] index,
                            logic [vbk_pkg::LVL_W-1:0] data);
        case (index)
            vbk_pkg::REG_PLUS_MODEL:       plus_model = data[0];
            vbk_pkg::REG_VOLUME_MAX:       volume_max = data;
            vbk_pkg::REG_BRIGHTNESS_MAX:   brightness_max = data;
            vbk_pkg::REG_START_VOLUME:
            begin
                start_volume = data;
                volume_now   = data;
            end
            vbk_pkg::REG_START_BRIGHTNESS:
            begin
                start_brightness = data;
                brightness_now   = data;
            end
            vbk_pkg::REG_START_MUTE:
            begin
                start_mute = data[0];
                muted      = data[0];
            end
            default: ;
        endcase
    endfunction

    // Only every second repeat steps; press and release restart the phase.
    function logic paced(logic [vbk_pkg::VALUE_W-1:0] value);
        logic act;
        if (value == vbk_pkg::VAL_REPEAT)
        begin
            act          = repeat_phase;
            repeat_phase = ~repeat_phase;
        end
        else
        begin
            repeat_phase = 1'b0;
            act          = (value == vbk_pkg::VAL_PRESS);
        end
        return act;
    endfunction

    function void step_up();
        if (menu_held)
        begin
            if (brightness_now < brightness_max)
                brightness_now = brightness_now + 1'b1;
        end
        else
        begin
            if (volume_now < volume_max)
                volume_now = volume_now + 1'b1;
            if (volume_now != 0)
                muted = 1'b0;
        end
    endfunction

    function void step_down();
        if (menu_held)
        begin
            if (brightness_now != 0)
                brightness_now = brightness_now - 1'b1;
        end
        else
        begin
            if (volume_now != 0)
                volume_now = volume_now - 1'b1;
            if (volume_now == 0)
                muted = 1'b1;
        end
    endfunction

    function void take_event(logic key, logic [vbk_pkg::CODE_W-1:0] code,
                             logic [vbk_pkg::VALUE_W-1:0] value);
        vbk_pkg::result_t levels;
        levels.shutdown_request = 1'b0;
        if (key && value <= vbk_pkg::VAL_REPEAT)
        begin
            if (code == vbk_pkg::CODE_MENU)
            begin
                if (value != vbk_pkg::VAL_REPEAT)
                    menu_held = value[0];
            end
            else if (code == vbk_pkg::CODE_POWER)
            begin
                if (value != vbk_pkg::VAL_REPEAT)
                    power_held = value[0];
            end
            else if (code == vbk_pkg::CODE_VOLUP || (code == vbk_pkg::CODE_R1 && !plus_model))
            begin
                if (paced(value))
                    step_up();
            end
            else if (code == vbk_pkg::CODE_VOLDOWN ||
                     (code == vbk_pkg::CODE_L1 && !plus_model))
            begin
                if (paced(value))
                    step_down();
            end
            if (menu_held && power_held)
            begin
                menu_held               = 1'b0;
                power_held              = 1'b0;
                levels.shutdown_request = 1'b1;
            end
        end
        levels.volume_level     = volume_now;
        levels.brightness_level = brightness_now;
        levels.mute_on          = muted;
        expected_levels.push_back(levels);
    endfunction

    function void compare(string field, logic [vbk_pkg::LVL_W-1:0] want,
                          logic [vbk_pkg::LVL_W-1:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    function void check_levels(vbk_pkg::result_t got);
        vbk_pkg::result_t want;
        if (expected_levels.size() == 0)
        begin
            errors++;
            $display("%0t: result expected none, got vol %0d bri %0d mute %0b shut %0b",
                     $time, got.volume_level, got.brightness_level, got.mute_on,
                     got.shutdown_request);
            return;
        end
        want = expected_levels.pop_front();
        compare("volume_level", want.volume_level, got.volume_level);
        compare("brightness_level", want.brightness_level, got.brightness_level);
        compare("mute_on", want.mute_on, got.mute_on);
        compare("shutdown_request", want.shutdown_request, got.shutdown_request);
    endfunction

    function int unsigned pending();
        return expected_levels.size();
    endfunction
endclass

module volume_brightness_key_controller_core_tb;
    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    logic                               is_key_event = 1'b0;
    logic [vbk_pkg::CODE_W-1:0]         key_code = '0;
    logic signed [vbk_pkg::VALUE_W-1:0] key_value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic [vbk_pkg::LVL_W-1:0]          volume_level;
    logic [vbk_pkg::LVL_W-1:0]          brightness_level;
    logic                               mute_on;
    logic                               shutdown_request;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [vbk_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [vbk_pkg::LVL_W-1:0]          cfg_data = '0;

    bit                                 no_idle = 1'b0;
    bit                                 hold_req = 1'b0;
    int unsigned                        items_sent = 0;
    level_tracker                       tracker = new();

    volume_brightness_key_controller_core dut (.*);

    always #10 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                tracker.take_event(is_key_event, key_code, key_value);
            if (out_valid && !out_stall)
                tracker.check_levels({volume_level, brightness_level, mute_on,
                                      shutdown_request});
            if (cfg_valid && cfg_ready)
                tracker.write_reg(cfg_index, cfg_data);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(24, 6);
    endfunction

    function automatic logic [vbk_pkg::CODE_W-1:0] pick_key();
        case ($urandom_range(5))
            0:       return vbk_pkg::CODE_MENU;
            1:       return vbk_pkg::CODE_POWER;
            2:       return vbk_pkg::CODE_VOLUP;
            3:       return vbk_pkg::CODE_VOLDOWN;
            4:       return vbk_pkg::CODE_L1;
            default: return vbk_pkg::CODE_R1;
        endcase
    endfunction

    function automatic logic [vbk_pkg::LVL_W-1:0] pick_level();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return vbk_pkg::LVL_W'($urandom_range(63));
        endcase
    endfunction

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        int unsigned gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (80) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = pick_gap();
                if (gap != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            @(negedge clk);
        end
    end

    task automatic send_event(input logic key, input logic [vbk_pkg::CODE_W-1:0] code,
                              input logic [vbk_pkg::VALUE_W-1:0] value);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            {is_key_event, key_code, key_value} <= 19'($urandom);
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        is_key_event <= key;
        key_code     <= code;
        key_value    <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic set_reg(input logic [vbk_pkg::CFG_IDX_W-1:0] index,
                           input logic [vbk_pkg::LVL_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Press, a run of repeats, usually a release; sometimes under menu.
    task automatic send_burst();
        logic [vbk_pkg::CODE_W-1:0] code;
        int unsigned                reps;
        bit                         with_menu;
        case ($urandom_range(5))
            0, 4:    code = vbk_pkg::CODE_VOLUP;
            1, 5:    code = vbk_pkg::CODE_VOLDOWN;
            2:       code = vbk_pkg::CODE_R1;
            default: code = vbk_pkg::CODE_L1;
        endcase
        reps      = $urandom_range(7);
        with_menu = ($urandom_range(4) == 0);
        if (with_menu)
            send_event(1'b1, vbk_pkg::CODE_MENU, vbk_pkg::VAL_PRESS);
        send_event(1'b1, code, vbk_pkg::VAL_PRESS);
        repeat (reps)
            send_event(1'b1, code, vbk_pkg::VAL_REPEAT);
        if ($urandom_range(3) != 0)
            send_event(1'b1, code, vbk_pkg::VAL_RELEASE);
        if (with_menu)
            send_event(1'b1, vbk_pkg::CODE_MENU, vbk_pkg::VAL_RELEASE);
    endtask

    task automatic send_noise();
        logic [vbk_pkg::CODE_W-1:0]  code;
        logic [vbk_pkg::VALUE_W-1:0] value;
        code  = $urandom_range(1) ? vbk_pkg::CODE_W'($urandom) : pick_key();
        value = $urandom_range(1) ? vbk_pkg::VALUE_W'($urandom_range(2)) :
                                    vbk_pkg::VALUE_W'($urandom);
        send_event($urandom_range(9) != 0, code, value);
    endtask

    task automatic send_chord();
        logic [vbk_pkg::CODE_W-1:0] first;
        logic [vbk_pkg::CODE_W-1:0] second;
        first  = $urandom_range(1) ? vbk_pkg::CODE_MENU : vbk_pkg::CODE_POWER;
        second = (first == vbk_pkg::CODE_MENU) ? vbk_pkg::CODE_POWER : vbk_pkg::CODE_MENU;
        send_event(1'b1, first, vbk_pkg::VAL_PRESS);
        if ($urandom_range(2) == 0)
            send_event(1'b1, first, vbk_pkg::VAL_REPEAT);
        if ($urandom_range(3) == 0)
            send_event(1'b1, first, vbk_pkg::VAL_RELEASE);
        send_event(1'b1, second, vbk_pkg::VAL_PRESS);
    endtask

    task automatic run_random(input int unsigned count);
        int unsigned stop;
        int unsigned r;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            r = $urandom_range(99);
            if (r < 60)
                send_burst();
            else if (r < 85)
                send_noise();
            else
                send_chord();
        end
        drain();
    endtask

    task automatic shuffle_regs();
        for (int i = 0; i < 2**vbk_pkg::CFG_IDX_W; i++)
            if ($urandom_range(2) != 0)
                set_reg(vbk_pkg::CFG_IDX_W'(i), pick_level());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ignored events: not a key, out-of-range values
        send_event(1'b0, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, 8'd3);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, 8'hff);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, 8'h80);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, 8'h7f);
        // repeat pacing
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_REPEAT);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_REPEAT);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_RELEASE);
        send_event(1'b1, vbk_pkg::CODE_VOLDOWN, vbk_pkg::VAL_PRESS);
        // shoulder keys and unknown codes do nothing on the plus model
        send_event(1'b1, vbk_pkg::CODE_R1, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_L1, vbk_pkg::VAL_PRESS);
        send_event(1'b1, '1, vbk_pkg::VAL_PRESS);
        send_event(1'b1, '0, vbk_pkg::VAL_PRESS);
        // brightness under menu, then the shutdown chord
        send_event(1'b1, vbk_pkg::CODE_MENU, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_MENU, vbk_pkg::VAL_REPEAT);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_VOLDOWN, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_POWER, vbk_pkg::VAL_REPEAT);
        send_event(1'b1, vbk_pkg::CODE_POWER, vbk_pkg::VAL_PRESS);
        drain();

        // level loaded above its maximum, shoulder keys live
        set_reg(vbk_pkg::REG_PLUS_MODEL, '0);
        set_reg(vbk_pkg::REG_VOLUME_MAX, '0);
        set_reg(vbk_pkg::REG_BRIGHTNESS_MAX, '1);
        set_reg(vbk_pkg::REG_START_VOLUME, '1);
        set_reg(vbk_pkg::REG_START_BRIGHTNESS, '0);
        set_reg(vbk_pkg::REG_START_MUTE, 6'd1);
        send_event(1'b1, vbk_pkg::CODE_R1, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_L1, vbk_pkg::VAL_PRESS);
        drain();

        // mute at the bottom, up at a zero maximum keeps it muted
        set_reg(vbk_pkg::REG_START_VOLUME, 6'd1);
        send_event(1'b1, vbk_pkg::CODE_VOLDOWN, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_VOLDOWN, vbk_pkg::VAL_PRESS);
        send_event(1'b1, vbk_pkg::CODE_VOLUP, vbk_pkg::VAL_PRESS);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            shuffle_regs();
            no_idle = (p == 2 || p == 4);
            if (p == 4)
                hold_req = 1'b1;
            run_random(118);
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(negedge clk);
        if (tracker.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
